// ----- rtl/whp_pkg.sv -----
// Package for the WAV header parser: parse phases, chunk tags, error codes
// and the result record. Depends on nothing.
package whp_pkg;

   // Chunk tags as little-endian words
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_FACT = 32'h7463_6166;
   localparam logic [31:0] TAG_LIST = 32'h5453_494C;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [31:0] FMT_PCM        = 32'd1;
   localparam logic [31:0] FMT_EXTENSIBLE = 32'd65534;
   localparam logic [31:0] FMT_SIZE_BASE  = 32'd16;
   localparam logic [31:0] FMT_SIZE_MID   = 32'd18;
   localparam logic [31:0] FMT_SIZE_EXT   = 32'd40;
   localparam logic [5:0]  FMT_BASE_LEN   = 6'd16;

   localparam logic [31:0] BITS_8  = 32'd8;
   localparam logic [31:0] BITS_16 = 32'd16;
   localparam logic [31:0] BITS_24 = 32'd24;
   localparam logic [31:0] BITS_32 = 32'd32;

   localparam logic [2:0] MAX_CHANNELS_RESET = 3'd6;

   localparam logic [1:0] STYPE_UINT  = 2'd0;
   localparam logic [1:0] STYPE_SINT  = 2'd1;
   localparam logic [1:0] STYPE_FLOAT = 2'd2;

   localparam logic [3:0] ERR_NONE       = 4'd0;
   localparam logic [3:0] ERR_RIFF_TAG   = 4'd1;
   localparam logic [3:0] ERR_RIFF_SIZE  = 4'd2;
   localparam logic [3:0] ERR_WAVE_TAG   = 4'd3;
   localparam logic [3:0] ERR_FMT_TAG    = 4'd4;
   localparam logic [3:0] ERR_FMT_SIZE   = 4'd5;
   localparam logic [3:0] ERR_FORMAT     = 4'd6;
   localparam logic [3:0] ERR_CHANNELS   = 4'd7;
   localparam logic [3:0] ERR_RATE       = 4'd8;
   localparam logic [3:0] ERR_BITS       = 4'd9;
   localparam logic [3:0] ERR_FACT_SIZE  = 4'd10;
   localparam logic [3:0] ERR_LIST_SIZE  = 4'd11;
   localparam logic [3:0] ERR_CHUNK_TAG  = 4'd12;
   localparam logic [3:0] ERR_DATA_SIZE  = 4'd13;
   localparam logic [3:0] ERR_FLOAT_BITS = 4'd14;

   typedef enum logic [4:0] {
      PH_RIFF_TAG  = 5'd0,
      PH_RIFF_SIZE = 5'd1,
      PH_WAVE_TAG  = 5'd2,
      PH_FMT_TAG   = 5'd3,
      PH_FMT_SIZE  = 5'd4,
      PH_FORMAT    = 5'd5,
      PH_CHANNELS  = 5'd6,
      PH_RATE      = 5'd7,
      PH_BYTERATE  = 5'd8,
      PH_ALIGN     = 5'd9,
      PH_BITS      = 5'd10,
      PH_EXT       = 5'd11,
      PH_TAG_A     = 5'd12,
      PH_FACT_SIZE = 5'd13,
      PH_FACT_SKIP = 5'd14,
      PH_TAG_B     = 5'd15,
      PH_LIST_SIZE = 5'd16,
      PH_LIST_SKIP = 5'd17,
      PH_TAG_C     = 5'd18,
      PH_DATA_SIZE = 5'd19,
      PH_PAYLOAD   = 5'd20,
      PH_DONE      = 5'd21,
      PH_ERROR     = 5'd22
   } phase_type;

   typedef struct packed {
      logic        header_done;
      logic [3:0]  error_code;
      logic        is_payload;
      logic [7:0]  payload_byte;
      logic        last_payload;
      logic [2:0]  num_channels;
      logic [30:0] sample_rate;
      logic [2:0]  bytes_per_sample;
      logic [1:0]  sample_type;
      logic [31:0] data_size;
      logic [31:0] data_offset;
   } rsp_type;

endpackage

// ----- rtl/wav_header_parser.sv -----
// WAV header parser top level: byte-serial RIFF/WAVE header checks and payload
// pass-through. Depends on whp_pkg.
//
//   channel | valid / ready          | word
//   --------+------------------------+-------------------------------------
//   req     | req_valid / req_ready  | one file byte plus start-of-file flag
//   rsp     | rsp_valid / rsp_ready  | one result per byte: flags + header
//   csr     | csr_valid / csr_ready  | max_channels (always ready)
//
// Parse state and the result word are computed in one pass from the accepted
// byte, then registered; one byte per cycle while the rsp side keeps up.
// The single result register decides the rate: a new byte is taken whenever
// that register is empty or is being drained in the same cycle.
// Reset (synchronous) returns the parser to expecting the RIFF tag and sets
// max_channels to 6. A stalled rsp side holds the result and stalls req.
module wav_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_start_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_header_done,
   output logic [3:0]  rsp_error_code,
   output logic        rsp_is_payload,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last_payload,
   output logic [2:0]  rsp_num_channels,
   output logic [30:0] rsp_sample_rate,
   output logic [2:0]  rsp_bytes_per_sample,
   output logic [1:0]  rsp_sample_type,
   output logic [31:0] rsp_data_size,
   output logic [31:0] rsp_data_offset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_max_channels
);
   import whp_pkg::*;

   // Configuration and parse state
   logic [2:0]  max_chan_ff;
   phase_type   phase_ff,   phase_in;
   logic [1:0]  idx_ff,     idx_in;
   logic [31:0] shift_ff,   shift_in;
   logic [31:0] skip_ff,    skip_in;
   logic [31:0] riff_ff,    riff_in;
   logic [5:0]  fmt_ff,     fmt_in;
   logic        float_ff,   float_in;
   logic [2:0]  chan_ff,    chan_in;
   logic [30:0] rate_ff,    rate_in;
   logic [5:0]  bits_ff,    bits_in;
   logic [31:0] payrem_ff,  payrem_in;
   logic [31:0] offset_ff,  offset_in;
   logic [3:0]  err_ff,     err_in;

   // Result register
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   // State as seen by this byte (start of file clears it first)
   logic        start;
   phase_type   cur_phase;
   logic [1:0]  cur_idx;
   logic [31:0] cur_shift, cur_skip, cur_riff, cur_payrem, cur_offset;
   logic [5:0]  cur_fmt, cur_bits;
   logic        cur_float;
   logic [2:0]  cur_chan;
   logic [30:0] cur_rate;
   logic [3:0]  cur_err;

   logic        accept;
   logic [31:0] field_word;
   logic        short_field, field_last, field_phase;
   logic [31:0] skip_dec, pay_dec;
   logic        skip_end, pay_end;
   logic        nonpos;
   logic        hdr_done;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   assign start      = req_start_of_file;
   assign cur_phase  = start ? PH_RIFF_TAG : phase_ff;
   assign cur_idx    = start ? 2'd0  : idx_ff;
   assign cur_shift  = start ? 32'd0 : shift_ff;
   assign cur_skip   = start ? 32'd0 : skip_ff;
   assign cur_riff   = start ? 32'd0 : riff_ff;
   assign cur_fmt    = start ? 6'd0  : fmt_ff;
   assign cur_float  = start ? 1'b0  : float_ff;
   assign cur_chan   = start ? 3'd0  : chan_ff;
   assign cur_rate   = start ? 31'd0 : rate_ff;
   assign cur_bits   = start ? 6'd0  : bits_ff;
   assign cur_payrem = start ? 32'd0 : payrem_ff;
   assign cur_offset = start ? 32'd0 : offset_ff;
   assign cur_err    = start ? ERR_NONE : err_ff;

   // Little-endian field assembly: drop this byte into its lane
   assign field_word = cur_shift | ({24'd0, req_in_byte} << {cur_idx, 3'b000});

   assign short_field = (cur_phase == PH_FORMAT) || (cur_phase == PH_CHANNELS) ||
                        (cur_phase == PH_ALIGN)  || (cur_phase == PH_BITS);
   assign field_last  = short_field ? (cur_idx == 2'd1) : (cur_idx == 2'd3);
   assign field_phase = (cur_phase <= PH_DATA_SIZE) && (cur_phase != PH_EXT) &&
                        (cur_phase != PH_FACT_SKIP) && (cur_phase != PH_LIST_SKIP);

   assign skip_dec = cur_skip - 32'd1;
   assign skip_end = (skip_dec == 32'd0);
   assign pay_dec  = cur_payrem - 32'd1;
   assign pay_end  = (pay_dec == 32'd0);

   // Rate, fact and LIST size fields read as signed: zero or negative is rejected
   assign nonpos = (field_word == 32'd0) || field_word[31];

   // Next state
   always_comb begin
      phase_in  = cur_phase;
      idx_in    = cur_idx;
      shift_in  = cur_shift;
      skip_in   = cur_skip;
      riff_in   = cur_riff;
      fmt_in    = cur_fmt;
      float_in  = cur_float;
      chan_in   = cur_chan;
      rate_in   = cur_rate;
      bits_in   = cur_bits;
      payrem_in = cur_payrem;
      offset_in = cur_offset + 32'd1;
      err_in    = cur_err;
      hdr_done  = 1'b0;

      if (field_phase) begin
         idx_in   = field_last ? 2'd0  : cur_idx + 2'd1;
         shift_in = field_last ? 32'd0 : field_word;
      end

      unique case (cur_phase)
         PH_PAYLOAD: begin
            payrem_in = pay_dec;
            if (pay_end) phase_in = PH_DONE;
         end
         PH_EXT: begin
            skip_in = skip_dec;
            if (skip_end) phase_in = PH_TAG_A;
         end
         PH_FACT_SKIP: begin
            skip_in = skip_dec;
            if (skip_end) phase_in = PH_TAG_B;
         end
         PH_LIST_SKIP: begin
            skip_in = skip_dec;
            if (skip_end) phase_in = PH_TAG_C;
         end
         PH_DONE, PH_ERROR: begin
            // hold: ignore bytes until the next file
         end
         PH_RIFF_TAG: if (field_last) begin
            if (field_word != TAG_RIFF) begin
               err_in = ERR_RIFF_TAG; phase_in = PH_ERROR;
            end else phase_in = PH_RIFF_SIZE;
         end
         PH_RIFF_SIZE: if (field_last) begin
            if (field_word == 32'd0) begin
               err_in = ERR_RIFF_SIZE; phase_in = PH_ERROR;
            end else begin
               riff_in = field_word; phase_in = PH_WAVE_TAG;
            end
         end
         PH_WAVE_TAG: if (field_last) begin
            if (field_word != TAG_WAVE) begin
               err_in = ERR_WAVE_TAG; phase_in = PH_ERROR;
            end else phase_in = PH_FMT_TAG;
         end
         PH_FMT_TAG: if (field_last) begin
            if (field_word != TAG_FMT) begin
               err_in = ERR_FMT_TAG; phase_in = PH_ERROR;
            end else phase_in = PH_FMT_SIZE;
         end
         PH_FMT_SIZE: if (field_last) begin
            if (field_word != FMT_SIZE_BASE && field_word != FMT_SIZE_MID &&
                field_word != FMT_SIZE_EXT) begin
               err_in = ERR_FMT_SIZE; phase_in = PH_ERROR;
            end else begin
               fmt_in = field_word[5:0]; phase_in = PH_FORMAT;
            end
         end
         PH_FORMAT: if (field_last) begin
            if (field_word != FMT_PCM && field_word != FMT_EXTENSIBLE) begin
               err_in = ERR_FORMAT; phase_in = PH_ERROR;
            end else phase_in = PH_CHANNELS;
         end
         PH_CHANNELS: if (field_last) begin
            if (field_word == 32'd0 || field_word > {29'd0, max_chan_ff}) begin
               err_in = ERR_CHANNELS; phase_in = PH_ERROR;
            end else begin
               chan_in = field_word[2:0]; phase_in = PH_RATE;
            end
         end
         PH_RATE: if (field_last) begin
            if (nonpos) begin
               err_in = ERR_RATE; phase_in = PH_ERROR;
            end else begin
               rate_in = field_word[30:0]; phase_in = PH_BYTERATE;
            end
         end
         PH_BYTERATE: if (field_last) phase_in = PH_ALIGN;
         PH_ALIGN:    if (field_last) phase_in = PH_BITS;
         PH_BITS: if (field_last) begin
            if (field_word != BITS_8 && field_word != BITS_16 &&
                field_word != BITS_24 && field_word != BITS_32) begin
               err_in = ERR_BITS; phase_in = PH_ERROR;
            end else begin
               bits_in = field_word[5:0];
               if (cur_fmt > FMT_BASE_LEN) begin
                  skip_in  = {26'd0, cur_fmt - FMT_BASE_LEN};
                  phase_in = PH_EXT;
               end else phase_in = PH_TAG_A;
            end
         end
         PH_TAG_A: if (field_last) begin
            if (field_word == TAG_FACT)      phase_in = PH_FACT_SIZE;
            else if (field_word == TAG_LIST) phase_in = PH_LIST_SIZE;
            else if (field_word == TAG_DATA) phase_in = PH_DATA_SIZE;
            else begin
               err_in = ERR_CHUNK_TAG; phase_in = PH_ERROR;
            end
         end
         PH_FACT_SIZE: if (field_last) begin
            if (nonpos) begin
               err_in = ERR_FACT_SIZE; phase_in = PH_ERROR;
            end else begin
               skip_in  = field_word + {31'd0, field_word[0]};
               float_in = 1'b1;
               phase_in = PH_FACT_SKIP;
            end
         end
         PH_TAG_B: if (field_last) begin
            if (field_word == TAG_LIST)      phase_in = PH_LIST_SIZE;
            else if (field_word == TAG_DATA) phase_in = PH_DATA_SIZE;
            else begin
               err_in = ERR_CHUNK_TAG; phase_in = PH_ERROR;
            end
         end
         PH_LIST_SIZE: if (field_last) begin
            if (nonpos) begin
               err_in = ERR_LIST_SIZE; phase_in = PH_ERROR;
            end else begin
               skip_in  = field_word + {31'd0, field_word[0]};
               phase_in = PH_LIST_SKIP;
            end
         end
         PH_TAG_C: if (field_last) begin
            if (field_word == TAG_DATA) phase_in = PH_DATA_SIZE;
            else begin
               err_in = ERR_CHUNK_TAG; phase_in = PH_ERROR;
            end
         end
         PH_DATA_SIZE: if (field_last) begin
            if (field_word == 32'd0 || field_word > cur_riff) begin
               err_in = ERR_DATA_SIZE; phase_in = PH_ERROR;
            end else if (cur_float && cur_bits != BITS_32[5:0]) begin
               err_in = ERR_FLOAT_BITS; phase_in = PH_ERROR;
            end else begin
               payrem_in = field_word;
               hdr_done  = 1'b1;
               phase_in  = PH_PAYLOAD;
            end
         end
         default: begin
            // hold: unused phase codes never advance
         end
      endcase
   end

   // Result word for this byte
   always_comb begin
      rsp_in            = '0;
      rsp_in.error_code = err_in;
      if (cur_phase == PH_PAYLOAD) begin
         rsp_in.is_payload   = 1'b1;
         rsp_in.payload_byte = req_in_byte;
         rsp_in.last_payload = pay_end;
      end
      if (hdr_done) begin
         rsp_in.header_done      = 1'b1;
         rsp_in.num_channels     = cur_chan;
         rsp_in.sample_rate      = cur_rate;
         rsp_in.bytes_per_sample = cur_bits[5:3];
         rsp_in.sample_type      = cur_float ? STYPE_FLOAT :
                                   (cur_bits > BITS_8[5:0]) ? STYPE_SINT : STYPE_UINT;
         rsp_in.data_size        = field_word;
         rsp_in.data_offset      = offset_in;
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_chan_ff <= MAX_CHANNELS_RESET;
      end else if (csr_valid && csr_ready) begin
         max_chan_ff <= csr_max_channels;
      end
   end

   // Parse state: advance on every accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_RIFF_TAG;
         idx_ff    <= 2'd0;
         shift_ff  <= 32'd0;
         skip_ff   <= 32'd0;
         riff_ff   <= 32'd0;
         fmt_ff    <= 6'd0;
         float_ff  <= 1'b0;
         chan_ff   <= 3'd0;
         rate_ff   <= 31'd0;
         bits_ff   <= 6'd0;
         payrem_ff <= 32'd0;
         offset_ff <= 32'd0;
         err_ff    <= ERR_NONE;
      end else if (accept) begin
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         shift_ff  <= shift_in;
         skip_ff   <= skip_in;
         riff_ff   <= riff_in;
         fmt_ff    <= fmt_in;
         float_ff  <= float_in;
         chan_ff   <= chan_in;
         rate_ff   <= rate_in;
         bits_ff   <= bits_in;
         payrem_ff <= payrem_in;
         offset_ff <= offset_in;
         err_ff    <= err_in;
      end
   end

   // Result register: load on accept, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_header_done      = rsp_ff.header_done;
   assign rsp_error_code       = rsp_ff.error_code;
   assign rsp_is_payload       = rsp_ff.is_payload;
   assign rsp_payload_byte     = rsp_ff.payload_byte;
   assign rsp_last_payload     = rsp_ff.last_payload;
   assign rsp_num_channels     = rsp_ff.num_channels;
   assign rsp_sample_rate      = rsp_ff.sample_rate;
   assign rsp_bytes_per_sample = rsp_ff.bytes_per_sample;
   assign rsp_sample_type      = rsp_ff.sample_type;
   assign rsp_data_size        = rsp_ff.data_size;
   assign rsp_data_offset      = rsp_ff.data_offset;

`ifndef SYNTHESIS
   // A completed header never carries an error
   a_hdr_no_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_header_done |-> rsp_error_code == ERR_NONE)
      else $error("header_done with error code set");

   // Header and payload flags exclude each other
   a_hdr_not_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_header_done |-> !rsp_is_payload)
      else $error("header_done on a payload byte");

   // Last marker only on payload
   a_last_is_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_payload |-> rsp_is_payload)
      else $error("last_payload outside payload");

   // Error phase always holds a nonzero code
   a_err_latched: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERROR |-> err_ff != ERR_NONE)
      else $error("error phase without error code");

   // After the last payload byte the parser sits in done
   a_last_to_done: assert property (@(posedge clock) disable iff (reset)
      accept && cur_phase == PH_PAYLOAD && pay_end |=> phase_ff == PH_DONE)
      else $error("parser left payload without reaching done");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for wav_header_parser: streams whole and broken WAV files
// byte by byte, predicts every result word and compares it. Depends on whp_pkg.
module testbench;
   import whp_pkg::*;

   // One byte of the file stream as it goes onto the req channel
   typedef struct packed {
      logic       sof;
      logic [7:0] data;
   } req_word;

   // Shape of one file to send; fields are written as they land in the stream
   typedef struct {
      logic [31:0] riff_tag;
      logic [31:0] riff_len;
      logic [31:0] wave_tag;
      logic [31:0] fmt_tag;
      logic [31:0] fmt_chunk_len;
      logic [15:0] format;
      logic [15:0] chans;
      logic [31:0] rate;
      logic [15:0] bits;
      int          n_chunks;
      logic [31:0] ck_tag [3];
      logic [31:0] ck_len [3];
      logic [31:0] data_len;
      int          pay_count;   // payload bytes actually sent
      int          tail;        // stray bytes after the payload
      int          cut;         // stop the file after this many bytes, 0 = whole
      bit          sof;
   } wav_spec;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'd0;
   logic        req_start_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_header_done;
   logic [3:0]  rsp_error_code;
   logic        rsp_is_payload;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_last_payload;
   logic [2:0]  rsp_num_channels;
   logic [30:0] rsp_sample_rate;
   logic [2:0]  rsp_bytes_per_sample;
   logic [1:0]  rsp_sample_type;
   logic [31:0] rsp_data_size;
   logic [31:0] rsp_data_offset;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_max_channels = 3'd0;

   wav_header_parser DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_in_byte          (req_in_byte),
      .req_start_of_file    (req_start_of_file),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_header_done      (rsp_header_done),
      .rsp_error_code       (rsp_error_code),
      .rsp_is_payload       (rsp_is_payload),
      .rsp_payload_byte     (rsp_payload_byte),
      .rsp_last_payload     (rsp_last_payload),
      .rsp_num_channels     (rsp_num_channels),
      .rsp_sample_rate      (rsp_sample_rate),
      .rsp_bytes_per_sample (rsp_bytes_per_sample),
      .rsp_sample_type      (rsp_sample_type),
      .rsp_data_size        (rsp_data_size),
      .rsp_data_offset      (rsp_data_offset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_channels     (csr_max_channels)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Bytes waiting for the driver, and result words waiting for the DUT
   req_word     file_stream [$];
   rsp_type     expected_words [$];
   logic [7:0]  file_bytes [$];
   req_word     next_word;
   rsp_type     seen_word;

   // Parser image kept by the bench
   phase_type   ph;
   int          fidx;
   logic [31:0] acc;
   logic [31:0] skip_left;
   logic [31:0] riff_len;
   logic [31:0] fmt_len;
   logic        fact_seen;
   logic [2:0]  chans;
   logic [30:0] rate;
   logic [5:0]  bits;
   logic [31:0] pay_left;
   logic [31:0] offs;
   logic [3:0]  err;
   logic [2:0]  cap_limit;

   bit          steady = 1'b0;   // set to suppress idling on both channels
   int          fail_count = 0;
   int          live_count = 0;  // bytes that the parser did not ignore
   int          files_sent = 0;
   int          bytes_sent = 0;
   int          headers_seen = 0;
   int          payload_seen = 0;
   logic [15:0] errs_seen = '0;

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------
   function automatic void clear_parser();
      ph        = PH_RIFF_TAG;
      fidx      = 0;
      acc       = '0;
      skip_left = '0;
      riff_len  = '0;
      fmt_len   = '0;
      fact_seen = 1'b0;
      chans     = '0;
      rate      = '0;
      bits      = '0;
      pay_left  = '0;
      offs      = '0;
      err       = ERR_NONE;
   endfunction

   function automatic void latch_fault(logic [3:0] code);
      err = code;
      ph  = PH_ERROR;
   endfunction

   // Format, channels, block align and bits are 16-bit fields; the rest are 32
   function automatic int field_bytes(phase_type p);
      if (p == PH_FORMAT || p == PH_CHANNELS || p == PH_ALIGN || p == PH_BITS)
         return 2;
      return 4;
   endfunction

   // Advance the parser image by one byte and return the word it should emit
   function automatic rsp_type parse_byte(logic [7:0] b, logic sof);
      rsp_type     r;
      logic [31:0] v;
      r = '0;
      if (sof)
         clear_parser();
      offs = offs + 32'd1;
      if (ph != PH_DONE && ph != PH_ERROR)
         live_count++;
      case (ph)
         PH_PAYLOAD: begin
            r.is_payload   = 1'b1;
            r.payload_byte = b;
            pay_left       = pay_left - 32'd1;
            if (pay_left == 32'd0) begin
               r.last_payload = 1'b1;
               ph             = PH_DONE;
            end
         end
         PH_EXT, PH_FACT_SKIP, PH_LIST_SKIP: begin
            skip_left = skip_left - 32'd1;
            if (skip_left == 32'd0) begin
               if (ph == PH_EXT)
                  ph = PH_TAG_A;
               else if (ph == PH_FACT_SKIP)
                  ph = PH_TAG_B;
               else
                  ph = PH_TAG_C;
            end
         end
         PH_DONE, PH_ERROR: ;
         default: begin
            acc = acc | ({24'd0, b} << (8 * fidx));
            if (fidx + 1 < field_bytes(ph)) begin
               fidx++;
            end else begin
               v    = acc;
               acc  = '0;
               fidx = 0;
               case (ph)
                  PH_RIFF_TAG:
                     if (v != TAG_RIFF) latch_fault(ERR_RIFF_TAG);
                     else ph = PH_RIFF_SIZE;
                  PH_RIFF_SIZE:
                     if (v == 32'd0) latch_fault(ERR_RIFF_SIZE);
                     else begin
                        riff_len = v;
                        ph       = PH_WAVE_TAG;
                     end
                  PH_WAVE_TAG:
                     if (v != TAG_WAVE) latch_fault(ERR_WAVE_TAG);
                     else ph = PH_FMT_TAG;
                  PH_FMT_TAG:
                     if (v != TAG_FMT) latch_fault(ERR_FMT_TAG);
                     else ph = PH_FMT_SIZE;
                  PH_FMT_SIZE:
                     if (v != FMT_SIZE_BASE && v != FMT_SIZE_MID && v != FMT_SIZE_EXT)
                        latch_fault(ERR_FMT_SIZE);
                     else begin
                        fmt_len = v;
                        ph      = PH_FORMAT;
                     end
                  PH_FORMAT:
                     if (v != FMT_PCM && v != FMT_EXTENSIBLE) latch_fault(ERR_FORMAT);
                     else ph = PH_CHANNELS;
                  PH_CHANNELS:
                     if (v == 32'd0 || v > {29'd0, cap_limit}) latch_fault(ERR_CHANNELS);
                     else begin
                        chans = v[2:0];
                        ph    = PH_RATE;
                     end
                  PH_RATE:
                     if (v == 32'd0 || v[31]) latch_fault(ERR_RATE);
                     else begin
                        rate = v[30:0];
                        ph   = PH_BYTERATE;
                     end
                  PH_BYTERATE: ph = PH_ALIGN;
                  PH_ALIGN:    ph = PH_BITS;
                  PH_BITS:
                     if (v != BITS_8 && v != BITS_16 && v != BITS_24 && v != BITS_32)
                        latch_fault(ERR_BITS);
                     else begin
                        bits = v[5:0];
                        if (fmt_len > FMT_SIZE_BASE) begin
                           skip_left = fmt_len - FMT_SIZE_BASE;
                           ph        = PH_EXT;
                        end else begin
                           ph = PH_TAG_A;
                        end
                     end
                  PH_TAG_A:
                     if (v == TAG_FACT) ph = PH_FACT_SIZE;
                     else if (v == TAG_LIST) ph = PH_LIST_SIZE;
                     else if (v == TAG_DATA) ph = PH_DATA_SIZE;
                     else latch_fault(ERR_CHUNK_TAG);
                  PH_FACT_SIZE:
                     if (v == 32'd0 || v[31]) latch_fault(ERR_FACT_SIZE);
                     else begin
                        // odd bodies carry one pad byte
                        skip_left = v + {31'd0, v[0]};
                        fact_seen = 1'b1;
                        ph        = PH_FACT_SKIP;
                     end
                  PH_TAG_B:
                     if (v == TAG_LIST) ph = PH_LIST_SIZE;
                     else if (v == TAG_DATA) ph = PH_DATA_SIZE;
                     else latch_fault(ERR_CHUNK_TAG);
                  PH_LIST_SIZE:
                     if (v == 32'd0 || v[31]) latch_fault(ERR_LIST_SIZE);
                     else begin
                        skip_left = v + {31'd0, v[0]};
                        ph        = PH_LIST_SKIP;
                     end
                  PH_TAG_C:
                     if (v == TAG_DATA) ph = PH_DATA_SIZE;
                     else latch_fault(ERR_CHUNK_TAG);
                  PH_DATA_SIZE:
                     if (v == 32'd0 || v > riff_len) latch_fault(ERR_DATA_SIZE);
                     else if (fact_seen && {26'd0, bits} != BITS_32)
                        latch_fault(ERR_FLOAT_BITS);
                     else begin
                        r.header_done      = 1'b1;
                        r.num_channels     = chans;
                        r.sample_rate      = rate;
                        r.bytes_per_sample = bits[5:3];
                        if (fact_seen)
                           r.sample_type = STYPE_FLOAT;
                        else if (bits > 6'd8)
                           r.sample_type = STYPE_SINT;
                        else
                           r.sample_type = STYPE_UINT;
                        r.data_size   = v;
                        r.data_offset = offs;
                        pay_left      = v;
                        ph            = PH_PAYLOAD;
                     end
                  default: ;
               endcase
            end
         end
      endcase
      r.error_code = err;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // File builder
   // ---------------------------------------------------------------------
   function automatic void put_le(logic [31:0] v, int n);
      for (int i = 0; i < n; i++)
         file_bytes.push_back(v[8*i +: 8]);
   endfunction

   function automatic void put_noise(int n);
      for (int i = 0; i < n; i++)
         file_bytes.push_back(8'($urandom));
   endfunction

   function automatic wav_spec plain_file();
      wav_spec s;
      s.riff_tag      = TAG_RIFF;
      s.riff_len      = 32'd64;
      s.wave_tag      = TAG_WAVE;
      s.fmt_tag       = TAG_FMT;
      s.fmt_chunk_len = FMT_SIZE_BASE;
      s.format        = FMT_PCM[15:0];
      s.chans         = 16'd2;
      s.rate          = 32'd44100;
      s.bits          = BITS_16[15:0];
      s.n_chunks      = 0;
      s.data_len      = 32'd4;
      s.pay_count     = 4;
      s.tail          = 0;
      s.cut           = 0;
      s.sof           = 1'b1;
      return s;
   endfunction

   function automatic wav_spec with_chunk(wav_spec s, logic [31:0] tag, logic [31:0] len);
      s.ck_tag[s.n_chunks] = tag;
      s.ck_len[s.n_chunks] = len;
      s.n_chunks++;
      return s;
   endfunction

   // Serialize one file and append it to the stream
   function automatic void queue_file(wav_spec s);
      int n;
      file_bytes.delete();
      put_le(s.riff_tag, 4);
      put_le(s.riff_len, 4);
      put_le(s.wave_tag, 4);
      put_le(s.fmt_tag, 4);
      put_le(s.fmt_chunk_len, 4);
      put_le({16'd0, s.format}, 2);
      put_le({16'd0, s.chans}, 2);
      put_le(s.rate, 4);
      put_noise(6);                        // byte rate and block align
      put_le({16'd0, s.bits}, 2);
      if (s.fmt_chunk_len == FMT_SIZE_MID || s.fmt_chunk_len == FMT_SIZE_EXT)
         put_noise(int'(s.fmt_chunk_len) - 16);
      for (int c = 0; c < s.n_chunks; c++) begin
         put_le(s.ck_tag[c], 4);
         put_le(s.ck_len[c], 4);
         // only small bodies are sent; large or negative sizes fail first
         if (s.ck_len[c] < 32'd64)
            put_noise(int'(s.ck_len[c]) + int'(s.ck_len[c][0]));
      end
      put_le(TAG_DATA, 4);
      put_le(s.data_len, 4);
      put_noise(s.pay_count + s.tail);
      n = (s.cut > 0 && s.cut < file_bytes.size()) ? s.cut : file_bytes.size();
      for (int i = 0; i < n; i++)
         file_stream.push_back('{sof: (i == 0) ? s.sof : 1'b0, data: file_bytes[i]});
      files_sent++;
      bytes_sent += n;
   endfunction

   // Mostly well-formed files with random content; about a quarter broken
   function automatic wav_spec random_file();
      wav_spec s;
      int      pick;
      s = plain_file();
      pick = $urandom_range(2);
      s.fmt_chunk_len = (pick == 0) ? FMT_SIZE_BASE :
                        (pick == 1) ? FMT_SIZE_MID : FMT_SIZE_EXT;
      s.format   = $urandom_range(1) ? FMT_PCM[15:0] : FMT_EXTENSIBLE[15:0];
      s.chans    = 16'($urandom_range(cap_limit, 1));
      s.rate     = ($urandom_range(3) == 0) ? $urandom_range(32'h7FFF_FFFF, 1)
                                            : 32'd8000 + $urandom_range(88200);
      s.bits     = 16'(8 * $urandom_range(4, 1));
      if ($urandom_range(2) == 0) begin
         s = with_chunk(s, TAG_FACT, $urandom_range(9, 1));
         if ($urandom_range(3) != 0)
            s.bits = BITS_32[15:0];
      end
      if ($urandom_range(2) == 0)
         s = with_chunk(s, TAG_LIST, $urandom_range(9, 1));
      s.data_len  = $urandom_range(12, 1);
      pick = $urandom_range(7);
      s.riff_len  = (pick == 0) ? s.data_len :
                    (pick == 1) ? ($urandom | s.data_len) : s.data_len + $urandom_range(5000);
      s.pay_count = int'(s.data_len);
      s.tail      = ($urandom_range(2) == 0) ? $urandom_range(3, 1) : 0;
      s.sof       = ($urandom_range(9) != 0);
      if ($urandom_range(3) == 0) begin
         case ($urandom_range(15))
            0:  s.riff_tag ^= 32'd1 << $urandom_range(31);
            1:  s.riff_len = 32'd0;
            2:  s.wave_tag ^= 32'd1 << $urandom_range(31);
            3:  s.fmt_tag ^= 32'd1 << $urandom_range(31);
            4:  s.fmt_chunk_len = $urandom_range(63);
            5:  s.format = 16'($urandom);
            6:  s.chans = $urandom_range(1) ? 16'd0 : 16'($urandom_range(65535, cap_limit + 1));
            7:  s.rate = $urandom_range(1) ? 32'd0 : ($urandom | 32'h8000_0000);
            8:  s.bits = 16'($urandom_range(40));
            9:  s = with_chunk(s, TAG_FACT, $urandom_range(1) ? 32'd0 : $urandom | 32'h8000_0000);
            10: s = with_chunk(s, TAG_LIST, $urandom_range(1) ? 32'd0 : $urandom | 32'h8000_0000);
            11: s = with_chunk(s, $urandom, 32'd2);
            12: s.data_len = $urandom_range(1) ? 32'd0 : s.riff_len + 32'd1;
            13: begin
               s = with_chunk(s, TAG_FACT, 32'd4);
               s.bits = BITS_16[15:0];
            end
            14: s.cut = $urandom_range(60, 1);
            default: s.pay_count = $urandom_range(int'(s.data_len) - 1);
         endcase
      end
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: feed the req channel from file_stream, predict on every accept
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_words.push_back(parse_byte(req_in_byte, req_start_of_file));
         // hold the current word until it is taken; otherwise load or idle
         if (!req_valid || req_ready) begin
            if (file_stream.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
               next_word = file_stream.pop_front();
               req_valid         <= 1'b1;
               req_in_byte       <= next_word.data;
               req_start_of_file <= next_word.sof;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: stall the rsp channel at random, check each word taken
   // ---------------------------------------------------------------------
   task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] seen);
      fail_count++;
      if (fail_count <= 40)
         $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, seen);
   endtask

   task automatic check_word(rsp_type seen, rsp_type want);
      if (seen.header_done !== want.header_done)
         flag_mismatch("header_done", 64'(want.header_done), 64'(seen.header_done));
      if (seen.error_code !== want.error_code)
         flag_mismatch("error_code", 64'(want.error_code), 64'(seen.error_code));
      if (seen.is_payload !== want.is_payload)
         flag_mismatch("is_payload", 64'(want.is_payload), 64'(seen.is_payload));
      if (seen.payload_byte !== want.payload_byte)
         flag_mismatch("payload_byte", 64'(want.payload_byte), 64'(seen.payload_byte));
      if (seen.last_payload !== want.last_payload)
         flag_mismatch("last_payload", 64'(want.last_payload), 64'(seen.last_payload));
      if (seen.num_channels !== want.num_channels)
         flag_mismatch("num_channels", 64'(want.num_channels), 64'(seen.num_channels));
      if (seen.sample_rate !== want.sample_rate)
         flag_mismatch("sample_rate", 64'(want.sample_rate), 64'(seen.sample_rate));
      if (seen.bytes_per_sample !== want.bytes_per_sample)
         flag_mismatch("bytes_per_sample", 64'(want.bytes_per_sample),
                       64'(seen.bytes_per_sample));
      if (seen.sample_type !== want.sample_type)
         flag_mismatch("sample_type", 64'(want.sample_type), 64'(seen.sample_type));
      if (seen.data_size !== want.data_size)
         flag_mismatch("data_size", 64'(want.data_size), 64'(seen.data_size));
      if (seen.data_offset !== want.data_offset)
         flag_mismatch("data_offset", 64'(want.data_offset), 64'(seen.data_offset));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen_word = {rsp_header_done, rsp_error_code, rsp_is_payload, rsp_payload_byte,
                         rsp_last_payload, rsp_num_channels, rsp_sample_rate,
                         rsp_bytes_per_sample, rsp_sample_type, rsp_data_size,
                         rsp_data_offset};
            if (expected_words.size() == 0) begin
               flag_mismatch("unexpected word", 64'd0, 64'(seen_word.error_code));
            end else begin
               check_word(seen_word, expected_words.pop_front());
               headers_seen += int'(seen_word.header_done);
               payload_seen += int'(seen_word.is_payload);
               errs_seen[seen_word.error_code] = 1'b1;
            end
         end
         rsp_ready <= steady || ($urandom_range(99) >= 30);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // Wait for every queued byte to go in and every result word to come out
   task automatic wait_idle();
      do @(posedge clock);
      while (file_stream.size() != 0 || req_valid || expected_words.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Write the channel limit; only called while the parser is idle
   task automatic set_max_channels(logic [2:0] limit);
      @(posedge clock);
      csr_valid        <= 1'b1;
      csr_max_channels <= limit;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      cap_limit = limit;
   endtask

   initial begin
      wav_spec     s;
      int          batch_start;
      logic [2:0]  batch_caps [5];
      clear_parser();
      cap_limit = MAX_CHANNELS_RESET;
      batch_caps = '{3'd1, 3'd4, 3'd7, 3'd2, 3'd6};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed files, channel limit at its reset value.
      // First file has no start flag: the parser must take it from offset 0,
      // and the stray bytes after its payload must be ignored.
      s = plain_file(); s.sof = 1'b0; s.tail = 3; queue_file(s);
      // extended format, 8-bit mono, top sample rate, odd LIST with pad, one-byte payload
      s = plain_file(); s.fmt_chunk_len = FMT_SIZE_MID; s.format = FMT_EXTENSIBLE[15:0];
      s.chans = 16'd1; s.rate = 32'h7FFF_FFFF; s.bits = BITS_8[15:0];
      s = with_chunk(s, TAG_LIST, 32'd3); s.data_len = 32'd1; s.pay_count = 1;
      queue_file(s);
      // float: fact then LIST, 40-byte fmt, six channels
      s = plain_file(); s.fmt_chunk_len = FMT_SIZE_EXT; s.chans = 16'd6;
      s.bits = BITS_32[15:0];
      s = with_chunk(s, TAG_FACT, 32'd5); s = with_chunk(s, TAG_LIST, 32'd2);
      s.data_len = 32'd3; s.pay_count = 3;
      queue_file(s);
      s = plain_file(); s.bits = BITS_24[15:0]; s.rate = 32'd1; queue_file(s);
      // largest sizes; the next start flag cuts the payload short
      s = plain_file(); s.bits = BITS_32[15:0]; s.riff_len = '1; s.data_len = '1;
      s.pay_count = 2;
      queue_file(s);
      // restart in the middle of the RIFF size field
      s = plain_file(); s.cut = 6; queue_file(s);

      // One file per header check; each stops one byte past the failing field
      s = plain_file(); s.riff_tag = 32'h5846_4952; s.cut = 5; queue_file(s);
      s = plain_file(); s.riff_len = 32'd0; s.cut = 9; queue_file(s);
      s = plain_file(); s.wave_tag = ~TAG_WAVE; s.cut = 13; queue_file(s);
      s = plain_file(); s.fmt_tag = 32'h2074_6D46; s.cut = 17; queue_file(s);
      s = plain_file(); s.fmt_chunk_len = 32'd17; s.cut = 21; queue_file(s);
      s = plain_file(); s.format = 16'd3; s.cut = 23; queue_file(s);
      s = plain_file(); s.chans = 16'd0; s.cut = 25; queue_file(s);
      s = plain_file(); s.chans = 16'd7; s.cut = 25; queue_file(s);
      s = plain_file(); s.rate = 32'd0; s.cut = 29; queue_file(s);
      s = plain_file(); s.rate = 32'h8000_0000; s.cut = 29; queue_file(s);
      s = plain_file(); s.bits = 16'd12; s.cut = 37; queue_file(s);
      s = plain_file(); s = with_chunk(s, TAG_FACT, 32'd0); s.cut = 45; queue_file(s);
      s = plain_file(); s = with_chunk(s, TAG_LIST, 32'hFFFF_FFFF); s.cut = 45;
      queue_file(s);
      // unknown tag after fmt, a second fact, a second LIST
      s = plain_file(); s = with_chunk(s, 32'h6B6E_756A, 32'd4); s.cut = 41; queue_file(s);
      s = plain_file(); s.bits = BITS_32[15:0];
      s = with_chunk(s, TAG_FACT, 32'd4); s = with_chunk(s, TAG_FACT, 32'd4); s.cut = 53;
      queue_file(s);
      s = plain_file();
      s = with_chunk(s, TAG_LIST, 32'd2); s = with_chunk(s, TAG_LIST, 32'd2); s.cut = 51;
      queue_file(s);
      s = plain_file(); s.data_len = 32'd0; s.cut = 45; queue_file(s);
      s = plain_file(); s.riff_len = 32'd10; s.data_len = 32'd11; s.cut = 45; queue_file(s);
      // fact chunk present but integer samples
      s = plain_file(); s = with_chunk(s, TAG_FACT, 32'd4); s.cut = 57; queue_file(s);

      // Register extremes: zero rejects any file, seven lets seven channels in
      wait_idle();
      set_max_channels(3'd0);
      s = plain_file(); s.chans = 16'd1; s.cut = 25; queue_file(s);
      wait_idle();
      set_max_channels(3'd7);
      s = plain_file(); s.chans = 16'd7; queue_file(s);
      s = plain_file(); s.chans = 16'd8; s.cut = 25; queue_file(s);

      // Random files in batches, a different limit per batch; batch two runs
      // without any idling on either channel
      for (int b = 0; b < 5; b++) begin
         wait_idle();
         set_max_channels(batch_caps[b]);
         steady = (b == 2);
         batch_start = bytes_sent;
         while (bytes_sent - batch_start < (steady ? 140 : 40)) begin
            queue_file(random_file());
            while (file_stream.size() > 100)
               @(posedge clock);
         end
      end

      // Drain, then let the pipeline settle before the verdict
      wait_idle();
      repeat (20) @(posedge clock);
      $display("Sent %0d files, %0d bytes (%0d parsed): %0d headers decoded, %0d payload bytes",
               files_sent, bytes_sent, live_count, headers_seen, payload_seen);
      $display("Error codes observed (one bit per code): %b", errs_seen);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #2_000_000;
      $display("Timeout with %0d words outstanding", expected_words.size());
      $display("Some tests failed");
      $finish;
   end

endmodule
